[rtl/deq_pkg.sv]
// deque package: sizes, operation and status codes, request and result types, ring arithmetic
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 8;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int VAL_W  = 8;
  localparam int IDX_W  = 6;
  localparam int STAT_W = 3;
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [OP_W-1:0] OP_PUSH_TAIL  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_HEAD   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;
  localparam logic [OP_W-1:0] OP_RESIZE     = 3'd6;
  localparam logic [OP_W-1:0] OP_NONE       = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_TOO_BIG  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } request_t;

  typedef struct packed {
    logic [VAL_W-1:0]  read_data;
    logic [VAL_W-1:0]  front_data;
    logic [VAL_W-1:0]  back_data;
    logic [IDX_W-1:0]  elements;
    logic              is_empty;
    logic              is_full;
    logic [STAT_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr_a;
    logic [PTR_W-1:0]  raddr_b;
  } mem_req_t;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] n);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W+1)'(n);
    if (s >= (PTR_W+1)'(DEPTH)) s = s - (PTR_W+1)'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_sub(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] n);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W+1)'(DEPTH) - (PTR_W+1)'(n);
    if (s >= (PTR_W+1)'(DEPTH)) s = s - (PTR_W+1)'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

endpackage

[rtl/deq_ram.sv]
// generic ring store: one write port, two registered read ports
`timescale 1ns / 1ps

module deq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/deq_ctrl.sv]
// deque control: pointers, count, operation decode, fill sequencer and result register
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  deq_pkg::request_t         request,
  output logic                      busy,
  output logic                      done,
  output deq_pkg::result_t          result,
  output deq_pkg::mem_req_t         mem_req,
  input  logic [deq_pkg::DATA_W-1:0] q_a,
  input  logic [deq_pkg::DATA_W-1:0] q_b
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FILL  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_FETCH = 2'd3;

  logic [1:0]                  state;
  logic [deq_pkg::PTR_W-1:0]   front_ptr, front_ptr_next;
  logic [deq_pkg::PTR_W-1:0]   back_ptr, back_ptr_next;
  logic [deq_pkg::CNT_W-1:0]   held, held_next;
  logic [deq_pkg::STAT_W-1:0]  status, status_next;
  logic                        read_ok, read_ok_next;
  logic [deq_pkg::DATA_W-1:0]  rd_hold;
  logic [deq_pkg::PTR_W-1:0]   fill_addr, fill_addr_next;
  logic [deq_pkg::CNT_W-1:0]   fill_left, fill_left_next;
  logic [deq_pkg::DATA_W-1:0]  fill_val;
  logic                        fill_go;
  logic                        wr_en;
  logic [deq_pkg::PTR_W-1:0]   wr_addr;
  logic [deq_pkg::PTR_W-1:0]   rd_addr;
  logic [deq_pkg::CMP_W-1:0]   idx_c, held_c;
  logic                        accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign idx_c  = deq_pkg::CMP_W'(request.index);
  assign held_c = deq_pkg::CMP_W'(held);

  // decode of one request against the current pointers
  always_comb begin
    front_ptr_next = front_ptr;
    back_ptr_next  = back_ptr;
    held_next      = held;
    status_next    = deq_pkg::ST_OK;
    read_ok_next   = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    fill_go        = 1'b0;
    fill_addr_next = '0;
    fill_left_next = '0;
    rd_addr        = front_ptr;
    if (held != '0 && idx_c < held_c) begin
      rd_addr = deq_pkg::ring_add(front_ptr, deq_pkg::CNT_W'(request.index));
    end
    unique case (request.op)
      deq_pkg::OP_PUSH_TAIL, deq_pkg::OP_PUSH_FRONT: begin
        if (held >= deq_pkg::CNT_W'(deq_pkg::DEPTH)) begin
          status_next = deq_pkg::ST_FULL;
        end else if (held == '0) begin
          front_ptr_next = '0;
          back_ptr_next  = '0;
          held_next      = deq_pkg::CNT_W'(1);
          wr_en          = 1'b1;
          wr_addr        = '0;
        end else if (request.op == deq_pkg::OP_PUSH_TAIL) begin
          back_ptr_next = deq_pkg::ring_add(back_ptr, deq_pkg::CNT_W'(1));
          held_next     = held + deq_pkg::CNT_W'(1);
          wr_en         = 1'b1;
          wr_addr       = back_ptr_next;
        end else begin
          front_ptr_next = deq_pkg::ring_sub(front_ptr, deq_pkg::CNT_W'(1));
          held_next      = held + deq_pkg::CNT_W'(1);
          wr_en          = 1'b1;
          wr_addr        = front_ptr_next;
        end
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_POP_HEAD: begin
        if (held == '0) begin
          status_next = deq_pkg::ST_EMPTY;
        end else if (held == deq_pkg::CNT_W'(1)) begin
          front_ptr_next = '0;
          back_ptr_next  = '0;
          held_next      = '0;
        end else begin
          if (request.op == deq_pkg::OP_POP_BACK) begin
            back_ptr_next = deq_pkg::ring_sub(back_ptr, deq_pkg::CNT_W'(1));
          end else begin
            front_ptr_next = deq_pkg::ring_add(front_ptr, deq_pkg::CNT_W'(1));
          end
          held_next = held - deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::OP_READ: begin
        if (held == '0) begin
          status_next = deq_pkg::ST_EMPTY;
        end else if (idx_c >= held_c) begin
          status_next = deq_pkg::ST_RANGE;
        end else begin
          read_ok_next = 1'b1;
        end
      end
      deq_pkg::OP_CLEAR: begin
        front_ptr_next = '0;
        back_ptr_next  = '0;
        held_next      = '0;
      end
      deq_pkg::OP_RESIZE: begin
        if (idx_c > deq_pkg::CMP_W'(deq_pkg::DEPTH)) begin
          status_next = deq_pkg::ST_TOO_BIG;
        end else if (idx_c == '0) begin
          front_ptr_next = '0;
          back_ptr_next  = '0;
          held_next      = '0;
        end else if (idx_c < held_c) begin
          back_ptr_next = deq_pkg::ring_sub(back_ptr, deq_pkg::CNT_W'(held_c - idx_c));
          held_next     = deq_pkg::CNT_W'(request.index);
        end else if (idx_c > held_c) begin
          fill_go        = 1'b1;
          fill_left_next = deq_pkg::CNT_W'(idx_c - held_c);
          held_next      = deq_pkg::CNT_W'(request.index);
          if (held == '0) begin
            front_ptr_next = '0;
            fill_addr_next = '0;
            back_ptr_next  = deq_pkg::PTR_W'(idx_c - deq_pkg::CMP_W'(1));
          end else begin
            fill_addr_next = deq_pkg::ring_add(back_ptr, deq_pkg::CNT_W'(1));
            back_ptr_next  = deq_pkg::ring_add(back_ptr, fill_left_next);
          end
        end
      end
      deq_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // store port steering
  always_comb begin
    mem_req         = '0;
    mem_req.wdata   = (state == S_FILL) ? fill_val : request.value;
    mem_req.raddr_a = rd_addr;
    mem_req.raddr_b = back_ptr;
    unique case (state)
      S_IDLE: begin
        mem_req.we    = accept && wr_en;
        mem_req.waddr = wr_addr;
      end
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = fill_addr;
      end
      S_LOOK: begin
        mem_req.raddr_a = front_ptr;
      end
      S_FETCH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_ptr <= '0;
      back_ptr  <= '0;
      held      <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            front_ptr <= front_ptr_next;
            back_ptr  <= back_ptr_next;
            held      <= held_next;
            state     <= fill_go ? S_FILL : S_LOOK;
          end
        end
        S_FILL: begin
          if (fill_left == deq_pkg::CNT_W'(1)) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      status    <= status_next;
      read_ok   <= read_ok_next;
      fill_addr <= fill_addr_next;
      fill_left <= fill_left_next;
      fill_val  <= request.value;
    end
    if (state == S_FILL) begin
      fill_addr <= deq_pkg::ring_add(fill_addr, deq_pkg::CNT_W'(1));
      fill_left <= fill_left - deq_pkg::CNT_W'(1);
    end
    if (state == S_LOOK) begin
      rd_hold <= read_ok ? q_a : '0;
    end
    if (state == S_FETCH) begin
      result.read_data  <= deq_pkg::VAL_W'(rd_hold);
      result.front_data <= (held != '0) ? deq_pkg::VAL_W'(q_a) : '0;
      result.back_data  <= (held != '0) ? deq_pkg::VAL_W'(q_b) : '0;
      result.elements   <= deq_pkg::IDX_W'(held);
      result.is_empty   <= (held == '0);
      result.is_full    <= (held >= deq_pkg::CNT_W'(deq_pkg::DEPTH));
      result.status     <= status;
    end
  end

endmodule

[rtl/circular_deque_unit.sv]
// circular deque top level: control and ring store
`timescale 1ns / 1ps

// Fixed-capacity double-ended queue. A request is taken when start is high and
// busy is low; its result is registered on result and shown with done high for
// exactly one cycle, and cannot be held off. Push, pop, read, clear and
// shrinking resize go through these steps in order: update the pointers and
// write or read the store, read the front and back entries, register the
// result. A resize that grows the deque first writes each new entry in a fill
// state, since the fill goes through the single write port of the store. busy
// is low again in the cycle that shows done, so a new request can be taken
// while done is high.
module circular_deque_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  deq_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output deq_pkg::result_t  result
);

  deq_pkg::mem_req_t          mem_req;
  logic [deq_pkg::DATA_W-1:0] q_a;
  logic [deq_pkg::DATA_W-1:0] q_b;

  deq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .mem_req (mem_req),
    .q_a     (q_a),
    .q_b     (q_b)
  );

  deq_ram #(
    .DEPTH (deq_pkg::DEPTH),
    .WIDTH (deq_pkg::DATA_W)
  ) u_ram (
    .clk     (clk),
    .we      (mem_req.we),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .raddr_a (mem_req.raddr_a),
    .raddr_b (mem_req.raddr_b),
    .rdata_a (q_a),
    .rdata_b (q_b)
  );

endmodule

[rtl/deq_checker.sv]
// deque port checker and its bind to the top level
`timescale 1ns / 1ps

module deq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input deq_pkg::request_t request,
  input logic              busy,
  input logic              done,
  input deq_pkg::result_t  result
);

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (result.elements == '0)))
    else $error("empty flag disagrees with count");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_full ==
              (result.elements == deq_pkg::IDX_W'(deq_pkg::DEPTH))))
    else $error("full flag disagrees with count");

endmodule

bind circular_deque_unit deq_checker u_deq_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .request (request),
  .busy    (busy),
  .done    (done),
  .result  (result)
);
